>>> sv/lrhc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrhc_pkg
// shared widths, register indexes and stage records of the line rasterizer
// ----------------------------------------------------------------------------
package lrhc_pkg;

    localparam int COORD_W  = 6;
    localparam int HEIGHT_W = 16;
    localparam int COLOR_W  = 24;
    localparam int MAXH_W   = 15;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 24;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAX_HEIGHT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_NEG  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_ZERO = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_LOW  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_MID  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_HIGH = 3'd5;

    // divide by three: x * ceil(2^17 / 3) >> 17, exact for 15-bit x
    localparam int THIRD_SHIFT = 17;
    localparam logic [THIRD_SHIFT-1:0] THIRD_MUL = 17'd43691;

    typedef struct packed {
        logic [COLOR_W-1:0] neg;
        logic [COLOR_W-1:0] zero;
        logic [COLOR_W-1:0] low;
        logic [COLOR_W-1:0] mid;
        logic [COLOR_W-1:0] high;
        logic [MAXH_W-1:0]  third;
    } t_cfg;

    typedef struct packed {
        logic               x_major;
        logic [COORD_W-1:0] s_maj;
        logic [COORD_W-1:0] s_min;
        logic [COORD_W-1:0] n;
        logic [COORD_W-1:0] dabs;
        logic               neg;
        logic [COLOR_W-1:0] color;
    } t_seg;

endpackage

>>> sv/lrhc_setup.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrhc_setup
// two register stages: input capture, then axis, deltas and color band
// ----------------------------------------------------------------------------
module lrhc_setup
    import lrhc_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire logic [COORD_W-1:0]  i_first_x,
    input  wire logic [COORD_W-1:0]  i_first_y,
    input  wire logic [HEIGHT_W-1:0] i_first_height,
    input  wire logic [COORD_W-1:0]  i_second_x,
    input  wire logic [COORD_W-1:0]  i_second_y,
    input  wire logic [HEIGHT_W-1:0] i_second_height,
    input  wire t_cfg                i_cfg,
    output logic                     o_seg_valid,
    input  wire logic                i_seg_take,
    output t_seg                     o_seg
);

    logic                r_a_valid;
    logic [COORD_W-1:0]  r_ax, r_ay, r_bx, r_by;
    logic [HEIGHT_W-1:0] r_ah, r_bh;
    logic                r_b_valid;
    t_seg                r_seg;
    t_seg                n_seg;
    logic                b_free, a_adv;

    logic [COORD_W-1:0]  dx, dy, e_maj, e_min;
    logic                ah_pos_low, bh_pos_low, ah_mid, bh_mid;
    logic [MAXH_W:0]     two_third;

    assign b_free  = !r_b_valid || i_seg_take;
    assign a_adv   = r_a_valid && b_free;
    assign o_stall = r_a_valid && !b_free;

    always_comb begin
        dx = (r_ax > r_bx) ? r_ax - r_bx : r_bx - r_ax;
        dy = (r_ay > r_by) ? r_ay - r_by : r_by - r_ay;
        n_seg.x_major = dx > dy;
        if (n_seg.x_major) begin
            if (r_ax <= r_bx) begin
                n_seg.s_maj = r_ax; n_seg.s_min = r_ay; e_maj = r_bx; e_min = r_by;
            end else begin
                n_seg.s_maj = r_bx; n_seg.s_min = r_by; e_maj = r_ax; e_min = r_ay;
            end
        end else begin
            if (r_ay < r_by) begin
                n_seg.s_maj = r_ay; n_seg.s_min = r_ax; e_maj = r_by; e_min = r_bx;
            end else begin
                n_seg.s_maj = r_by; n_seg.s_min = r_bx; e_maj = r_ay; e_min = r_ax;
            end
        end
        n_seg.n    = e_maj - n_seg.s_maj;
        n_seg.neg  = e_min < n_seg.s_min;
        n_seg.dabs = n_seg.neg ? n_seg.s_min - e_min : e_min - n_seg.s_min;

        // band tests only matter once both heights are known positive
        two_third  = {i_cfg.third, 1'b0};
        ah_pos_low = r_ah[MAXH_W-1:0] <= i_cfg.third;
        bh_pos_low = r_bh[MAXH_W-1:0] <= i_cfg.third;
        ah_mid     = {1'b0, r_ah[MAXH_W-1:0]} < two_third;
        bh_mid     = {1'b0, r_bh[MAXH_W-1:0]} < two_third;
        if (r_ah[HEIGHT_W-1] || r_bh[HEIGHT_W-1]) begin
            n_seg.color = i_cfg.neg;
        end else if (r_ah == '0 || r_bh == '0) begin
            n_seg.color = i_cfg.zero;
        end else if (ah_pos_low || bh_pos_low) begin
            n_seg.color = i_cfg.low;
        end else if (ah_mid || bh_mid) begin
            n_seg.color = i_cfg.mid;
        end else begin
            n_seg.color = i_cfg.high;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (!o_stall) r_a_valid <= i_valid;
            if (b_free)   r_b_valid <= r_a_valid;
        end
        if (i_valid && !o_stall) begin
            r_ax <= i_first_x;  r_ay <= i_first_y;  r_ah <= i_first_height;
            r_bx <= i_second_x; r_by <= i_second_y; r_bh <= i_second_height;
        end
        if (a_adv) r_seg <= n_seg;
    end

    assign o_seg_valid = r_b_valid;
    assign o_seg       = r_seg;

endmodule
`default_nettype wire

>>> sv/lrhc_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrhc_step
// walks the major axis one pixel a cycle, unless the output stalls, with a remainder accumulator
// ----------------------------------------------------------------------------
module lrhc_step
    import lrhc_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_seg_valid,
    output logic                    o_seg_take,
    input  wire t_seg               i_seg,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [COORD_W-1:0]      o_pixel_x,
    output logic [COORD_W-1:0]      o_pixel_y,
    output logic [COLOR_W-1:0]      o_pixel_color,
    output logic                    o_last_pixel
);

    logic               r_busy;
    t_seg               r_seg;
    logic [COORD_W-1:0] r_k, r_q, r_acc;
    logic               r_out_valid;
    logic [COORD_W-1:0] r_px, r_py;
    logic [COLOR_W-1:0] r_color;
    logic               r_last;

    logic               emit, last;
    logic [COORD_W-1:0] major, minor;
    logic [COORD_W:0]   acc_sum;

    assign o_seg_take = !r_busy && i_seg_valid;
    assign emit       = r_busy && (!r_out_valid || !i_stall);
    assign last       = r_k == r_seg.n - 1'b1;
    assign major      = r_seg.s_maj + r_k;
    assign minor      = r_seg.neg ? r_seg.s_min - r_q : r_seg.s_min + r_q;
    assign acc_sum    = {1'b0, r_acc} + {1'b0, r_seg.dabs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_seg_take)
                r_busy <= i_seg.n != '0;
            else if (emit && last)
                r_busy <= 1'b0;
            if (emit)
                r_out_valid <= 1'b1;
            else if (!i_stall)
                r_out_valid <= 1'b0;
        end
        if (o_seg_take) begin
            r_seg <= i_seg;
            r_k   <= '0;
            r_q   <= '0;
            r_acc <= '0;
        end else if (emit) begin
            r_k <= r_k + 1'b1;
            if (acc_sum >= {1'b0, r_seg.n}) begin
                r_q   <= r_q + 1'b1;
                r_acc <= COORD_W'(acc_sum - {1'b0, r_seg.n});
            end else begin
                r_acc <= acc_sum[COORD_W-1:0];
            end
        end
        if (emit) begin
            r_px    <= r_seg.x_major ? major : minor;
            r_py    <= r_seg.x_major ? minor : major;
            r_color <= r_seg.color;
            r_last  <= last;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_pixel_x     = r_px;
    assign o_pixel_y     = r_py;
    assign o_pixel_color = r_color;
    assign o_last_pixel  = r_last;

endmodule
`default_nettype wire

>>> sv/line_raster_height_color.sv
`timescale 1ns / 1ps
`default_nettype none
// path: a segment passes the capture register, the setup register and the stepper's segment
// register before its first pixel reaches the output register, when the stepper is idle
// throughput: one pixel per cycle while i_stall is low; the stepper takes a new segment only
// after emitting the last pixel of the current one (a segment with coincident ends emits none)
// reset: synchronous active-low; clears valids, the stepper busy flag and configuration registers to 0
// ----------------------------------------------------------------------------
// line_raster_height_color
// segment to pixel rasterizer with a color picked from height bands
// ----------------------------------------------------------------------------
module line_raster_height_color
    import lrhc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // configuration writes
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    // segment items
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic [COORD_W-1:0]    i_first_x,
    input  wire logic [COORD_W-1:0]    i_first_y,
    input  wire logic [HEIGHT_W-1:0]   i_first_height,
    input  wire logic [COORD_W-1:0]    i_second_x,
    input  wire logic [COORD_W-1:0]    i_second_y,
    input  wire logic [HEIGHT_W-1:0]   i_second_height,
    // pixel items
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic [COORD_W-1:0]         o_pixel_x,
    output logic [COORD_W-1:0]         o_pixel_y,
    output logic [COLOR_W-1:0]         o_pixel_color,
    output logic                       o_last_pixel
);

    t_cfg                         r_cfg;
    logic [MAXH_W+THIRD_SHIFT-1:0] third_prod;
    logic                         seg_valid, seg_take;
    t_seg                         seg;

    // third of the max height is kept ready, computed on the write itself
    assign third_prod = i_cfg_data[MAXH_W-1:0] * THIRD_MUL;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_MAX_HEIGHT: r_cfg.third <= third_prod[MAXH_W+THIRD_SHIFT-1:THIRD_SHIFT];
                REG_COLOR_NEG:  r_cfg.neg   <= i_cfg_data[COLOR_W-1:0];
                REG_COLOR_ZERO: r_cfg.zero  <= i_cfg_data[COLOR_W-1:0];
                REG_COLOR_LOW:  r_cfg.low   <= i_cfg_data[COLOR_W-1:0];
                REG_COLOR_MID:  r_cfg.mid   <= i_cfg_data[COLOR_W-1:0];
                REG_COLOR_HIGH: r_cfg.high  <= i_cfg_data[COLOR_W-1:0];
                default: ;
            endcase
        end
    end

    // capture stage and setup stage
    lrhc_setup u_setup (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_first_x       (i_first_x),
        .i_first_y       (i_first_y),
        .i_first_height  (i_first_height),
        .i_second_x      (i_second_x),
        .i_second_y      (i_second_y),
        .i_second_height (i_second_height),
        .i_cfg           (r_cfg),
        .o_seg_valid     (seg_valid),
        .i_seg_take      (seg_take),
        .o_seg           (seg)
    );

    // pixel stepper with its output register
    lrhc_step u_step (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_seg_valid   (seg_valid),
        .o_seg_take    (seg_take),
        .i_seg         (seg),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_pixel_x     (o_pixel_x),
        .o_pixel_y     (o_pixel_y),
        .o_pixel_color (o_pixel_color),
        .o_last_pixel  (o_last_pixel)
    );

endmodule
`default_nettype wire
